// ----- src/chte_pkg.sv -----
// ----------------------------------------------------------------------------
// chte_pkg: shared types and constants of the chained hash table engine.
// Holds opcodes, status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package chte_pkg;

    localparam int NUM_BUCKETS_DEF  = 10;
    localparam int BUCKET_DEPTH_DEF = 4;
    localparam int KEY_CHARS_DEF    = 16;

    localparam int KEY_W   = 64;
    localparam int LEN_W   = 5;
    localparam int SCORE_W = 24;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_RANGE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

endpackage

// ----- src/chained_hash_table_engine.sv -----
// ----------------------------------------------------------------------------
// chained_hash_table_engine: separate-chaining hash table of scored records.
//
// Input channel s_* carries one command (insert, delete, lookup, range
// search); result channel m_* carries records with a last flag. Both
// channels use valid/ready; a transfer happens when both are high.
// A command is taken only while the sequencer is idle. The key hash is
// formed one character per cycle in a shared adder and reduced modulo the
// bucket count by a reciprocal multiply. Lookup and delete then compare one
// slot at a time (read, then compare, since the entry memory has a
// registered read); delete shifts the later slots down, reading each one
// and writing it one slot lower. Range search walks the filled slots of
// every bucket, emitting each match. The next command is taken the cycle
// after the last result is loaded. When the receiver stalls, the result
// register holds and the scan waits. Synchronous active-low reset clears
// the bucket fill counters, the output valid flag and the sequencer; the
// entry memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module chained_hash_table_engine #(
    parameter int NUM_BUCKETS  = chte_pkg::NUM_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = chte_pkg::BUCKET_DEPTH_DEF,
    parameter int KEY_CHARS    = chte_pkg::KEY_CHARS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_opcode,
    input  logic [chte_pkg::KEY_W-1:0]   s_key_high,
    input  logic [chte_pkg::KEY_W-1:0]   s_key_low,
    input  logic [chte_pkg::LEN_W-1:0]   s_key_length,
    input  logic signed [chte_pkg::SCORE_W-1:0] s_score_in,
    input  logic signed [chte_pkg::SCORE_W-1:0] s_range_low,
    input  logic signed [chte_pkg::SCORE_W-1:0] s_range_high,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [chte_pkg::KEY_W-1:0]   m_key_high_out,
    output logic [chte_pkg::KEY_W-1:0]   m_key_low_out,
    output logic [chte_pkg::LEN_W-1:0]   m_key_length_out,
    output logic signed [chte_pkg::SCORE_W-1:0] m_score_out,
    output logic                         m_last
);
    import chte_pkg::*;

    localparam int SLOTS  = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int BKT_W  = $clog2(NUM_BUCKETS);
    localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
    localparam int DEP_W  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int SUM_W  = 12;
    localparam int CH_W   = 5;
    localparam int KL_W   = $clog2(KEY_CHARS + 1);
    localparam int MEM_W  = 2 * KEY_W + LEN_W + SCORE_W;
    // Reciprocal of the bucket count, exact for every SUM_W-bit sum.
    localparam int RECIP_SH = SUM_W + $clog2(NUM_BUCKETS);
    localparam int RECIP    = ((1 << RECIP_SH) + NUM_BUCKETS - 1) / NUM_BUCKETS;
    localparam int PROD_W   = SUM_W + RECIP_SH + 1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_HASH  = 11'b00000000010,
        S_MOD   = 11'b00000000100,
        S_INS   = 11'b00000001000,
        S_RD    = 11'b00000010000,
        S_CMP   = 11'b00000100000,
        S_SHRD  = 11'b00001000000,
        S_SHWR  = 11'b00010000000,
        S_RRD   = 11'b00100000000,
        S_RCHK  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          op_reg;
    logic [KEY_W-1:0]    hi_reg, lo_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [SCORE_W-1:0]  score_reg;
    logic signed [SCORE_W-1:0] rlo_reg, rhi_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [BKT_W-1:0]    bkt_reg;
    logic [DEP_W-1:0]    slot_reg;
    logic [FILL_W-1:0]   fill_reg [NUM_BUCKETS];
    logic                found_reg;
    logic                scan_done_reg;

    logic [MEM_W-1:0]    mem [SLOTS];
    logic [MEM_W-1:0]    rd_data_reg;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_wa, mem_ra;
    logic [MEM_W-1:0]    mem_wd;

    logic                out_valid_reg;
    logic [1:0]          out_status_reg;
    logic [KEY_W-1:0]    out_hi_reg, out_lo_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic [SCORE_W-1:0]  out_score_reg;
    logic                out_last_reg;

    // Key normalization of the incoming command.
    logic [KL_W-1:0]     nlen;
    logic [KEY_W-1:0]    nhi, nlo;
    always_comb begin
        if (s_key_length > LEN_W'(KEY_CHARS)) nlen = KL_W'(KEY_CHARS);
        else nlen = KL_W'(s_key_length);
        for (int i = 0; i < 8; i++) begin
            nhi[KEY_W-1-8*i -: 8] = (i < int'(nlen)) ?
                                    s_key_high[KEY_W-1-8*i -: 8] : 8'd0;
            nlo[KEY_W-1-8*i -: 8] = (i + 8 < int'(nlen)) ?
                                    s_key_low[KEY_W-1-8*i -: 8] : 8'd0;
        end
    end

    // Current character for the hash adder.
    logic [7:0] cur_char;
    always_comb begin
        if (ch_reg < CH_W'(8)) cur_char = hi_reg[KEY_W-1-8*ch_reg[2:0] -: 8];
        else cur_char = lo_reg[KEY_W-1-8*ch_reg[2:0] -: 8];
    end

    // Remainder of the character sum by the bucket count.
    logic [PROD_W-1:0] recip_prod;
    logic [SUM_W-1:0]  mod_quot;
    logic [SUM_W-1:0]  mod_rem;
    assign recip_prod = PROD_W'(sum_reg) * PROD_W'(RECIP);
    assign mod_quot   = recip_prod[RECIP_SH +: SUM_W];
    assign mod_rem    = sum_reg - SUM_W'(mod_quot * NUM_BUCKETS);

    // Slot address of the current bucket and position.
    logic [SLOT_W-1:0] slot_addr;
    assign slot_addr = SLOT_W'(bkt_reg * BUCKET_DEPTH) + SLOT_W'(slot_reg);

    // Fields of the read record.
    logic [KEY_W-1:0]   rd_hi, rd_lo;
    logic [LEN_W-1:0]   rd_len;
    logic [SCORE_W-1:0] rd_score;
    assign {rd_hi, rd_lo, rd_len, rd_score} = rd_data_reg;

    logic [FILL_W-1:0] cur_fill;
    assign cur_fill = fill_reg[bkt_reg];

    logic out_free;
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    logic last_slot;
    logic last_bkt;
    assign last_slot = (slot_reg == DEP_W'(BUCKET_DEPTH - 1));
    assign last_bkt  = (bkt_reg == BKT_W'(NUM_BUCKETS - 1));

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_valid) begin
                state_next = (s_opcode == OP_RANGE) ? S_RRD : S_HASH;
            end
            S_HASH: if (ch_reg >= CH_W'(len_reg)) state_next = S_MOD;
            S_MOD: if (sum_reg < SUM_W'(NUM_BUCKETS)) begin
                if (op_reg == OP_INSERT) state_next = S_INS;
                else state_next = S_RD;
            end
            S_INS: if (out_free) state_next = S_IDLE;
            S_RD: begin
                if (FILL_W'(slot_reg) >= cur_fill) state_next = S_OUT;
                else state_next = S_CMP;
            end
            S_CMP: begin
                if (rd_len == len_reg && rd_hi == hi_reg && rd_lo == lo_reg) begin
                    state_next = (op_reg == OP_DELETE) ? S_SHRD : S_OUT;
                end else if (last_slot) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_RD;
                end
            end
            S_SHRD: begin
                if (FILL_W'(slot_reg) + FILL_W'(1) >= cur_fill) state_next = S_OUT;
                else state_next = S_SHWR;
            end
            S_SHWR: state_next = S_SHRD;
            S_RRD: begin
                if (scan_done_reg) state_next = S_OUT;
                else if (FILL_W'(slot_reg) >= cur_fill) state_next = S_RRD;
                else state_next = S_RCHK;
            end
            S_RCHK: if (out_free) state_next = S_RRD;
            S_OUT: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Memory read address and write port.
    always_comb begin
        mem_ra = slot_addr;
        mem_we = 1'b0;
        mem_wa = slot_addr;
        mem_wd = {hi_reg, lo_reg, len_reg, score_reg};
        case (state_reg)
            S_INS: begin
                mem_we = out_free && (cur_fill < FILL_W'(BUCKET_DEPTH));
                mem_wa = SLOT_W'(bkt_reg * BUCKET_DEPTH) + SLOT_W'(cur_fill);
            end
            S_SHRD: mem_ra = slot_addr + SLOT_W'(1);
            S_SHWR: begin
                mem_we = 1'b1;
                mem_wd = rd_data_reg;
            end
            default: ;
        endcase
    end

    // Entry memory: one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    // Range match of the read record.
    logic in_range;
    assign in_range = ($signed(rd_score) >= rlo_reg) && ($signed(rd_score) <= rhi_reg);

    // A result is loaded into the output register at this edge.
    logic out_load;
    assign out_load = out_free && ((state_reg == S_INS) || (state_reg == S_OUT) ||
                                   (state_reg == S_RCHK && in_range && found_reg));

    // Datapath and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < NUM_BUCKETS; b++) fill_reg[b] <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (s_valid) begin
                    op_reg        <= s_opcode;
                    hi_reg        <= nhi;
                    lo_reg        <= nlo;
                    len_reg       <= LEN_W'(nlen);
                    score_reg     <= s_score_in;
                    rlo_reg       <= s_range_low;
                    rhi_reg       <= s_range_high;
                    sum_reg       <= '0;
                    ch_reg        <= '0;
                    bkt_reg       <= '0;
                    slot_reg      <= '0;
                    found_reg     <= 1'b0;
                    scan_done_reg <= 1'b0;
                end
                S_HASH: if (ch_reg < CH_W'(len_reg)) begin
                    sum_reg <= sum_reg + SUM_W'(cur_char);
                    ch_reg  <= ch_reg + CH_W'(1);
                end
                S_MOD: begin
                    if (sum_reg >= SUM_W'(NUM_BUCKETS)) sum_reg <= mod_rem;
                    else bkt_reg <= BKT_W'(sum_reg);
                end
                S_INS: if (out_free) begin
                    out_hi_reg     <= hi_reg;
                    out_lo_reg     <= lo_reg;
                    out_len_reg    <= len_reg;
                    out_score_reg  <= score_reg;
                    out_last_reg   <= 1'b1;
                    if (cur_fill >= FILL_W'(BUCKET_DEPTH)) begin
                        out_status_reg <= ST_FULL;
                    end else begin
                        out_status_reg    <= ST_OK;
                        fill_reg[bkt_reg] <= cur_fill + FILL_W'(1);
                    end
                end
                S_CMP: begin
                    if (rd_len == len_reg && rd_hi == hi_reg && rd_lo == lo_reg) begin
                        found_reg <= 1'b1;
                        score_reg <= rd_score;
                    end else if (!last_slot) begin
                        slot_reg <= slot_reg + DEP_W'(1);
                    end
                end
                S_SHRD: begin
                    if (FILL_W'(slot_reg) + FILL_W'(1) >= cur_fill) begin
                        fill_reg[bkt_reg] <= cur_fill - FILL_W'(1);
                    end
                end
                S_SHWR: slot_reg <= slot_reg + DEP_W'(1);
                S_RRD: begin
                    if (!scan_done_reg && FILL_W'(slot_reg) >= cur_fill) begin
                        slot_reg <= '0;
                        if (last_bkt) scan_done_reg <= 1'b1;
                        else bkt_reg <= bkt_reg + BKT_W'(1);
                    end
                end
                S_RCHK: if (out_free) begin
                    // The held match goes out once a later match shows it is not
                    // the final one; the key registers hold the newest match.
                    if (in_range) begin
                        if (found_reg) begin
                            out_status_reg <= ST_OK;
                            out_hi_reg     <= hi_reg;
                            out_lo_reg     <= lo_reg;
                            out_len_reg    <= len_reg;
                            out_score_reg  <= score_reg;
                            out_last_reg   <= 1'b0;
                        end
                        found_reg <= 1'b1;
                        hi_reg    <= rd_hi;
                        lo_reg    <= rd_lo;
                        len_reg   <= rd_len;
                        score_reg <= rd_score;
                    end
                    if (last_slot) begin
                        slot_reg <= '0;
                        if (last_bkt) scan_done_reg <= 1'b1;
                        else bkt_reg <= bkt_reg + BKT_W'(1);
                    end else begin
                        slot_reg <= slot_reg + DEP_W'(1);
                    end
                end
                S_OUT: if (out_free) begin
                    out_last_reg <= 1'b1;
                    if (op_reg == OP_RANGE) begin
                        if (found_reg) begin
                            out_status_reg <= ST_OK;
                            out_hi_reg     <= hi_reg;
                            out_lo_reg     <= lo_reg;
                            out_len_reg    <= len_reg;
                            out_score_reg  <= score_reg;
                        end else begin
                            out_status_reg <= ST_NOTFOUND;
                            out_hi_reg     <= '0;
                            out_lo_reg     <= '0;
                            out_len_reg    <= '0;
                            out_score_reg  <= '0;
                        end
                    end else begin
                        out_status_reg <= found_reg ? ST_OK : ST_NOTFOUND;
                        out_hi_reg     <= hi_reg;
                        out_lo_reg     <= lo_reg;
                        out_len_reg    <= len_reg;
                        out_score_reg  <= found_reg ? score_reg : '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_key_high_out   = out_hi_reg;
    assign m_key_low_out    = out_lo_reg;
    assign m_key_length_out = out_len_reg;
    assign m_score_out      = out_score_reg;
    assign m_last           = out_last_reg;

endmodule

// ----- tb/chte_checker.sv -----
// ----------------------------------------------------------------------------
// chte_checker: scoreboard for the chained hash table engine.
// Watches both channels, keeps its own copy of the table, predicts the
// records each accepted command produces and compares every result transfer.
// ----------------------------------------------------------------------------
module chte_checker #(
    parameter int NB = chte_pkg::NUM_BUCKETS_DEF,
    parameter int BD = chte_pkg::BUCKET_DEPTH_DEF,
    parameter int KC = chte_pkg::KEY_CHARS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [1:0]                          s_opcode,
    input  logic [chte_pkg::KEY_W-1:0]          s_key_high,
    input  logic [chte_pkg::KEY_W-1:0]          s_key_low,
    input  logic [chte_pkg::LEN_W-1:0]          s_key_length,
    input  logic signed [chte_pkg::SCORE_W-1:0] s_score_in,
    input  logic signed [chte_pkg::SCORE_W-1:0] s_range_low,
    input  logic signed [chte_pkg::SCORE_W-1:0] s_range_high,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [1:0]                          m_status,
    input  logic [chte_pkg::KEY_W-1:0]          m_key_high_out,
    input  logic [chte_pkg::KEY_W-1:0]          m_key_low_out,
    input  logic [chte_pkg::LEN_W-1:0]          m_key_length_out,
    input  logic signed [chte_pkg::SCORE_W-1:0] m_score_out,
    input  logic                                m_last,
    output int                                  fail_count,
    output int                                  pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import chte_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0]          hi;
        logic [KEY_W-1:0]          lo;
        logic [LEN_W-1:0]          len;
        logic signed [SCORE_W-1:0] score;
    } record_t;

    typedef struct packed {
        logic [1:0] status;
        record_t    rec;
        logic       last;
    } result_t;

    record_t table_slot [NB][BD];
    int      table_fill [NB];
    result_t expected_results [$];

    assign pending_count = expected_results.size();

    function automatic logic [KEY_W-1:0] char_mask(int n);
        if (n <= 0) return '0;
        if (n >= 8) return '1;
        return ~64'd0 << (64 - 8 * n);
    endfunction

    // Normalize the key exactly as the engine stores it.
    function automatic record_t norm_key(logic [KEY_W-1:0] hi, logic [KEY_W-1:0] lo,
                                         logic [LEN_W-1:0] len_in);
        record_t r;
        int      n;
        n = (len_in > KC) ? KC : len_in;
        r.len = LEN_W'(n);
        r.hi = hi & char_mask(n);
        r.lo = lo & char_mask(n - 8);
        r.score = '0;
        return r;
    endfunction

    function automatic int bucket_of(record_t k);
        int sum;
        sum = 0;
        for (int i = 0; i < k.len; i++) begin
            if (i < 8) sum += k.hi[63 - 8 * i -: 8];
            else sum += k.lo[63 - 8 * (i - 8) -: 8];
        end
        return sum % NB;
    endfunction

    function automatic void push_result(logic [1:0] st, record_t r, logic lst);
        result_t x;
        x.status = st;
        x.rec = r;
        x.last = lst;
        expected_results.insert(expected_results.size(), x);
    endfunction

    // Apply one command to the table copy and queue its results.
    function automatic void predict_command(logic [1:0] op, record_t k,
                                            logic signed [SCORE_W-1:0] lo_b,
                                            logic signed [SCORE_W-1:0] hi_b);
        int      b;
        int      hits;
        int      idx;
        record_t zero_rec;
        zero_rec = '0;
        if (op == OP_RANGE) begin
            hits = 0;
            for (int bb = 0; bb < NB; bb++)
                for (int i = 0; i < table_fill[bb]; i++)
                    if (table_slot[bb][i].score >= lo_b &&
                            table_slot[bb][i].score <= hi_b) begin
                        push_result(ST_OK, table_slot[bb][i], 1'b0);
                        hits++;
                    end
            if (hits == 0) push_result(ST_NOTFOUND, zero_rec, 1'b1);
            else expected_results[$].last = 1'b1;
            return;
        end
        b = bucket_of(k);
        if (op == OP_INSERT) begin
            if (table_fill[b] >= BD) begin
                push_result(ST_FULL, k, 1'b1);
            end else begin
                table_slot[b][table_fill[b]] = k;
                table_fill[b]++;
                push_result(ST_OK, k, 1'b1);
            end
            return;
        end
        idx = -1;
        for (int i = 0; i < table_fill[b]; i++)
            if (idx < 0 && table_slot[b][i].len == k.len && table_slot[b][i].hi == k.hi
                    && table_slot[b][i].lo == k.lo)
                idx = i;
        if (idx < 0) begin
            k.score = '0;
            push_result(ST_NOTFOUND, k, 1'b1);
        end else begin
            push_result(ST_OK, table_slot[b][idx], 1'b1);
            if (op == OP_DELETE) begin
                for (int j = idx; j + 1 < table_fill[b]; j++)
                    table_slot[b][j] = table_slot[b][j + 1];
                table_fill[b]--;
            end
        end
    endfunction

    // Sample both channels at each rising edge.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        record_t k;
        if (!aresetn) begin
            for (int i = 0; i < NB; i++) table_fill[i] = 0;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                got.status = m_status;
                got.rec.hi = m_key_high_out;
                got.rec.lo = m_key_low_out;
                got.rec.len = m_key_length_out;
                got.rec.score = m_score_out;
                got.last = m_last;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transfer %h", $time, got);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        fail_count++;
                    end
                    if (got.rec.hi !== want.rec.hi) begin
                        $display("%0t: key_high expected %h actual %h",
                                 $time, want.rec.hi, got.rec.hi);
                        fail_count++;
                    end
                    if (got.rec.lo !== want.rec.lo) begin
                        $display("%0t: key_low expected %h actual %h",
                                 $time, want.rec.lo, got.rec.lo);
                        fail_count++;
                    end
                    if (got.rec.len !== want.rec.len) begin
                        $display("%0t: key_length expected %0d actual %0d",
                                 $time, want.rec.len, got.rec.len);
                        fail_count++;
                    end
                    if (got.rec.score !== want.rec.score) begin
                        $display("%0t: score expected %0d actual %0d",
                                 $time, want.rec.score, got.rec.score);
                        fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, got.last);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                k = norm_key(s_key_high, s_key_low, s_key_length);
                k.score = s_score_in;
                predict_command(s_opcode, k, s_range_low, s_range_high);
            end
        end
    end
endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stimulus for the chained hash table engine.
// Drives directed and random commands over a small key pool with random
// idling on both channels; the checker module predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import chte_pkg::*;

    localparam int RANDOM_ITEMS = 380;
    localparam int CYCLE_LIMIT  = 400000;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_opcode = OP_INSERT;
    logic [KEY_W-1:0]          s_key_high = '0;
    logic [KEY_W-1:0]          s_key_low = '0;
    logic [LEN_W-1:0]          s_key_length = '0;
    logic signed [SCORE_W-1:0] s_score_in = '0;
    logic signed [SCORE_W-1:0] s_range_low = '0;
    logic signed [SCORE_W-1:0] s_range_high = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [1:0]                m_status;
    logic [KEY_W-1:0]          m_key_high_out;
    logic [KEY_W-1:0]          m_key_low_out;
    logic [LEN_W-1:0]          m_key_length_out;
    logic signed [SCORE_W-1:0] m_score_out;
    logic                      m_last;
    int                        fail_count;
    int                        pending_count;
    int                        cycle_count = 0;
    bit                        calm = 1'b0;
    logic [KEY_W-1:0]          pool_hi [8];
    logic [KEY_W-1:0]          pool_lo [8];
    logic [LEN_W-1:0]          pool_len [8];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    chained_hash_table_engine dut (.*);

    chte_checker checker_i (.*);

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver stalls in random bursts, none in the calm tail.
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 6);
                repeat (n - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Present one command and hold it until the transfer.
    task automatic send_command(logic [1:0] op, logic [KEY_W-1:0] hi,
                                logic [KEY_W-1:0] lo, logic [LEN_W-1:0] len,
                                logic [SCORE_W-1:0] sc, logic [SCORE_W-1:0] rl,
                                logic [SCORE_W-1:0] rh);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_key_high <= hi;
        s_key_low <= lo;
        s_key_length <= len;
        s_score_in <= sc;
        s_range_low <= rl;
        s_range_high <= rh;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [KEY_W-1:0] char_bits(logic [LEN_W-1:0] n);
        if (n == 0) return '0;
        if (n >= 8) return '1;
        return ~64'd0 << (64 - 8 * n);
    endfunction

    // Random command over the key pool, biased toward well-formed traffic.
    task automatic send_random;
        int  p;
        int  sel;
        logic [KEY_W-1:0] hi;
        logic [KEY_W-1:0] lo;
        logic [LEN_W-1:0] len;
        logic [SCORE_W-1:0] a;
        logic [SCORE_W-1:0] b;
        p = $urandom_range(0, 7);
        hi = pool_hi[p];
        lo = pool_lo[p];
        len = pool_len[p];
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
            len = LEN_W'($urandom_range(0, 31));
        end else if (sel == 1) begin
            // Same key with junk beyond its length.
            hi = hi | (~char_bits(len) & {$urandom, $urandom});
        end
        a = SCORE_W'($urandom);
        b = SCORE_W'($urandom);
        if ($urandom_range(0, 3) != 0 && $signed(a) > $signed(b)) begin
            a = b;
            b = SCORE_W'($urandom);
            if ($signed(a) > $signed(b)) b = a;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: send_command(OP_INSERT, hi, lo, len, SCORE_W'($urandom), a, b);
            4, 5:       send_command(OP_DELETE, hi, lo, len, SCORE_W'($urandom), a, b);
            6, 7:       send_command(OP_LOOKUP, hi, lo, len, SCORE_W'($urandom), a, b);
            default:    send_command(OP_RANGE, hi, lo, len, SCORE_W'($urandom), a, b);
        endcase
    endtask

    // Main sequence: reset, directed cases, random traffic, drain.
    initial begin
        int waited;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Extremes: empty key, full 16 characters, over-long length.
        send_command(OP_LOOKUP, '1, '1, 5'd0, '0, '0, '0);
        send_command(OP_INSERT, '1, '1, 5'd0, 24'h7FFFFF, '0, '0);
        send_command(OP_INSERT, '1, '1, 5'd16, 24'h800000, '0, '0);
        send_command(OP_INSERT, '1, '1, 5'd31, 24'h000001, '0, '0);
        send_command(OP_INSERT, 64'h4100_0000_0000_0000, '1, 5'd1, 24'hFFFFFF, '0, '0);
        // Duplicates of the empty key fill bucket 0, and the later ones find it full.
        send_command(OP_INSERT, '0, '0, 5'd0, 24'h000100, '0, '0);
        send_command(OP_INSERT, '0, '0, 5'd0, 24'h000200, '0, '0);
        send_command(OP_INSERT, '0, '0, 5'd0, 24'h000300, '0, '0);
        send_command(OP_LOOKUP, 64'h4100_0000_0000_0000, '0, 5'd1, '0, '0, '0);
        send_command(OP_LOOKUP, 64'h4200_0000_0000_0000, '0, 5'd1, '0, '0, '0);
        send_command(OP_RANGE, '0, '0, 5'd0, '0, 24'h800000, 24'h7FFFFF);
        send_command(OP_RANGE, '0, '0, 5'd0, '0, 24'h000100, 24'h000200);
        send_command(OP_RANGE, '0, '0, 5'd0, '0, 24'h000200, 24'h000100);
        send_command(OP_DELETE, '1, '1, 5'd0, '0, '0, '0);
        send_command(OP_DELETE, '1, '1, 5'd20, '0, '0, '0);
        send_command(OP_DELETE, 64'h4300_0000_0000_0000, '0, 5'd1, '0, '0, '0);
        send_command(OP_INSERT, '0, '0, 5'd0, 24'h000400, '0, '0);
        send_command(OP_RANGE, '0, '0, 5'd0, '0, 24'h800000, 24'h7FFFFF);
        // Key pool: five short keys and three longer keys.
        for (int i = 0; i < 8; i++) begin
            pool_len[i] = LEN_W'((i < 5) ? $urandom_range(1, 4) : $urandom_range(5, 16));
            pool_hi[i] = {$urandom, $urandom} & char_bits(pool_len[i]);
            pool_lo[i] = {$urandom, $urandom} &
                         char_bits((pool_len[i] > 5'd8) ? pool_len[i] - 5'd8 : 5'd0);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - 40) calm = 1'b1;
            send_random();
        end
        s_valid <= 1'b0;
        waited = 0;
        while (pending_count != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
